// ----- rtl/slt_pkg.sv -----
package slt_pkg;

    localparam int CAPACITY    = 32;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int OUT_COUNT_W = 6;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MEMBER = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DEDUPE = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } slt_wr_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [OUT_COUNT_W-1:0] count;
    } slt_res_t;

endpackage

// ----- rtl/slt_ram.sv -----
module slt_ram
    import slt_pkg::*;
(
    input  logic              aclk,
    input  slt_wr_t           wr,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/slt_ctrl.sv -----
module slt_ctrl
    import slt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  logic [CMD_W-1:0]  cmd_code,
    input  logic [DATA_W-1:0] cmd_value,
    output logic              res_valid,
    input  logic              res_ready,
    output slt_res_t          res,
    output slt_wr_t           wr,
    output logic              rd_en,
    output logic [IDX_W-1:0]  rd_addr,
    input  logic [DATA_W-1:0] rd_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0]          state_reg,     state_next;
    logic [CMD_W-1:0]    cmd_reg,       cmd_next;
    logic [DATA_W-1:0]   value_reg,     value_next;
    logic [CNT_W-1:0]    count_reg,     count_next;
    logic [CNT_W-1:0]    rem_reg,       rem_next;
    logic [IDX_W-1:0]    addr_reg,      addr_next;
    logic                pend_reg,      pend_next;
    logic [IDX_W-1:0]    pend_addr_reg, pend_addr_next;
    logic                flag_reg,      flag_next;
    logic                full_reg,      full_next;
    logic [CNT_W-1:0]    kept_reg,      kept_next;
    logic [DATA_W-1:0]   last_reg,      last_next;
    logic [STATUS_W-1:0] status_reg,    status_next;
    logic [CNT_W-1:0]    dec_cnt;

    assign dec_cnt   = count_reg - CNT_W'(1);
    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);
    assign res.status = status_reg;
    assign res.count  = OUT_COUNT_W'(count_reg);

    // reads and writes of one walk never hit the same entry in the same cycle:
    // insert writes one above the read, remove one below, dedupe at or below
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        addr_next      = addr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        flag_next      = flag_reg;
        full_next      = full_reg;
        kept_next      = kept_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        wr             = '0;
        rd_en          = 1'b0;
        rd_addr        = addr_reg;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_next   = cmd_code;
                    value_next = cmd_value;
                    flag_next  = 1'b0;
                    kept_next  = '0;
                    pend_next  = 1'b0;
                    full_next  = (cmd_code == CMD_INSERT) &&
                                 (count_reg >= CNT_W'(CAPACITY));
                    rem_next   = ((cmd_code == CMD_INSERT) &&
                                  (count_reg >= CNT_W'(CAPACITY))) ? '0 : count_reg;
                    // insert walks down from the top entry, the rest walk up
                    addr_next  = (cmd_code == CMD_INSERT) ? dec_cnt[IDX_W-1:0] : '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (rem_reg != '0) begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = addr_reg;
                    addr_next      = (cmd_reg == CMD_INSERT) ? addr_reg - IDX_W'(1)
                                                             : addr_reg + IDX_W'(1);
                    rem_next       = rem_reg - CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                end

                if (pend_reg) begin
                    case (cmd_reg)
                        CMD_INSERT: begin
                            if (!flag_reg) begin
                                wr.en   = 1'b1;
                                wr.addr = pend_addr_reg + IDX_W'(1);
                                if ($signed(rd_data) >= $signed(value_reg)) begin
                                    wr.data = rd_data;
                                end else begin
                                    wr.data   = value_reg;
                                    flag_next = 1'b1;
                                end
                            end
                        end
                        CMD_REMOVE: begin
                            if (flag_reg) begin
                                wr.en   = 1'b1;
                                wr.addr = pend_addr_reg - IDX_W'(1);
                                wr.data = rd_data;
                            end else if (rd_data == value_reg) begin
                                flag_next = 1'b1;
                            end
                        end
                        CMD_MEMBER: begin
                            if (rd_data == value_reg) begin
                                flag_next = 1'b1;
                            end
                        end
                        default: begin
                            if ((kept_reg == '0) || (last_reg != rd_data)) begin
                                wr.en     = 1'b1;
                                wr.addr   = kept_reg[IDX_W-1:0];
                                wr.data   = rd_data;
                                last_next = rd_data;
                                kept_next = kept_reg + CNT_W'(1);
                            end
                        end
                    endcase
                end

                if ((rem_reg == '0) && !pend_reg) begin
                    state_next = ST_RESP;
                    case (cmd_reg)
                        CMD_INSERT: begin
                            if (full_reg) begin
                                status_next = STATUS_FULL;
                            end else begin
                                // no held entry was smaller: value goes to the bottom
                                if (!flag_reg) begin
                                    wr.en   = 1'b1;
                                    wr.addr = '0;
                                    wr.data = value_reg;
                                end
                                count_next  = count_reg + CNT_W'(1);
                                status_next = STATUS_DONE;
                            end
                        end
                        CMD_REMOVE: begin
                            if (flag_reg) begin
                                count_next  = dec_cnt;
                                status_next = STATUS_DONE;
                            end else begin
                                status_next = STATUS_MISSING;
                            end
                        end
                        CMD_MEMBER: begin
                            status_next = flag_reg ? STATUS_DONE : STATUS_MISSING;
                        end
                        default: begin
                            count_next  = kept_reg;
                            status_next = STATUS_DONE;
                        end
                    endcase
                end
            end
            ST_RESP: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rem_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        value_reg     <= value_next;
        addr_reg      <= addr_next;
        pend_addr_reg <= pend_addr_next;
        flag_reg      <= flag_next;
        full_reg      <= full_next;
        kept_reg      <= kept_next;
        last_reg      <= last_next;
        status_reg    <= status_next;
    end

endmodule

// ----- rtl/sorted_list_table.sv -----
// Sorted table of up to CAPACITY signed 32-bit values in ascending order,
// duplicates allowed. Each command on s_ is one transfer and yields exactly
// one transfer on m_ carrying a status (done/found, not found, table full)
// and the entry count after the command. Commands run one at a time: the
// controller walks the held entries through a dual-port table memory, one
// read per cycle, shifting or compacting in the same pass; an insert into a
// full table skips the walk. The next command is taken while the previous
// result still sits in the output register.
module sorted_list_table
    import slt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // command[1:0], value[33:2], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // status[1:0], count[7:2]
);

    slt_wr_t           wr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              res_valid;
    logic              res_ready;
    slt_res_t          res;

    logic              m_tvalid_reg, m_tvalid_next;
    slt_res_t          out_reg,      out_next;

    slt_ram u_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    slt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd_code  (s_tdata[CMD_W-1:0]),
        .cmd_value (s_tdata[CMD_W+DATA_W-1:CMD_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr        (wr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // output register is free when empty or being drained this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.count, out_reg.status};

endmodule

// ----- tb/sorted_list_table_chk.sv -----
`timescale 1ns / 100ps

module sorted_list_table_chk
    import slt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    output int          errors,
    output int          pending,
    output int          checked,
    output int          full_refusals,
    output int          absent_hits
);

    // ascending copy of the table, duplicates kept
    logic signed [DATA_W-1:0] held_vals [CAPACITY];
    int                       held_count;
    slt_res_t                 table_results [$];
    slt_res_t                 want;
    slt_res_t                 got;

    function automatic slt_res_t apply_command(input logic [CMD_W-1:0] cmd,
                                               input logic signed [DATA_W-1:0] v);
        slt_res_t res;
        int       pos;
        int       i;
        int       kept;
        res.status = STATUS_DONE;
        case (cmd)
            CMD_INSERT: begin
                if (held_count >= CAPACITY) begin
                    res.status = STATUS_FULL;
                end else begin
                    pos = 0;
                    while (pos < held_count && held_vals[pos] < v)
                        pos++;
                    for (i = held_count; i > pos; i--)
                        held_vals[i] = held_vals[i-1];
                    held_vals[pos] = v;
                    held_count++;
                end
            end
            CMD_REMOVE, CMD_MEMBER: begin
                pos = 0;
                while (pos < held_count && held_vals[pos] != v)
                    pos++;
                if (pos >= held_count) begin
                    res.status = STATUS_MISSING;
                end else if (cmd == CMD_REMOVE) begin
                    for (i = pos; i + 1 < held_count; i++)
                        held_vals[i] = held_vals[i+1];
                    held_count--;
                end
            end
            default: begin
                kept = 0;
                for (i = 0; i < held_count; i++) begin
                    if (kept == 0 || held_vals[kept-1] != held_vals[i]) begin
                        held_vals[kept] = held_vals[i];
                        kept++;
                    end
                end
                held_count = kept;
            end
        endcase
        res.count = held_count[OUT_COUNT_W-1:0];
        return res;
    endfunction

    assign pending = table_results.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_count = 0;
            table_results.delete();
            errors = 0;
            checked = 0;
            full_refusals = 0;
            absent_hits = 0;
        end else begin
            // predict first so a same-edge result still finds its entry
            if (s_tvalid && s_tready) begin
                want = apply_command(s_tdata[1:0], s_tdata[33:2]);
                if (want.status == STATUS_FULL)
                    full_refusals++;
                if (want.status == STATUS_MISSING)
                    absent_hits++;
                table_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                checked++;
                got.status = m_tdata[1:0];
                got.count  = m_tdata[7:2];
                if (table_results.size() == 0) begin
                    $display("%0t: unexpected result transfer: status %0d count %0d",
                             $time, got.status, got.count);
                    errors++;
                end else begin
                    want = table_results.pop_front();
                    if (got.status != want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, got.status);
                        errors++;
                    end
                    if (got.count != want.count) begin
                        $display("%0t: count mismatch: expected %0d, actual %0d",
                                 $time, want.count, got.count);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/sorted_list_table_tb.sv -----
`timescale 1ns / 100ps

module sorted_list_table_tb;
    import slt_pkg::*;

    localparam int RANDOM_ITEMS = 1730;
    localparam int PHASE_LEN    = 120;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int POOL_SIZE    = 24;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    int errors;
    int pending;
    int checked;
    int full_refusals;
    int absent_hits;

    logic                     quiet = 1'b0;
    int                       cmd_counts [4];
    int                       stall_left = 0;
    int                       cycles = 0;
    logic signed [DATA_W-1:0] value_pool [POOL_SIZE];

    always #5 aclk = ~aclk;

    sorted_list_table u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sorted_list_table_chk u_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .errors        (errors),
        .pending       (pending),
        .checked       (checked),
        .full_refusals (full_refusals),
        .absent_hits   (absent_hits)
    );

    // random result side back-pressure in bursts
    always @(posedge aclk) begin
        if (stall_left == 0 && !quiet && aresetn && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 10);
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, val, cmd};
        do @(posedge aclk); while (!s_tready);
        cmd_counts[cmd]++;
    endtask

    function automatic logic [DATA_W-1:0] pool_value();
        return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    initial begin
        int                n;
        int                r;
        logic              filling;
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] val;

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        value_pool[4] = 32'h0000_0001;
        value_pool[5] = 32'hffff_fffe;
        for (int k = 6; k < POOL_SIZE; k++)
            value_pool[k] = $urandom;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, extremes, duplicates, absent values, dedupe
        send_cmd(CMD_MEMBER, 32'd5);
        send_cmd(CMD_REMOVE, 32'd5);
        send_cmd(CMD_DEDUPE, 32'hffff_ffff);
        send_cmd(CMD_INSERT, 32'h0000_0000);
        send_cmd(CMD_INSERT, 32'h7fff_ffff);
        send_cmd(CMD_INSERT, 32'h8000_0000);
        send_cmd(CMD_INSERT, 32'hffff_ffff);
        send_cmd(CMD_INSERT, 32'h0000_0000);
        send_cmd(CMD_INSERT, 32'h7fff_ffff);
        send_cmd(CMD_MEMBER, 32'h8000_0000);
        send_cmd(CMD_MEMBER, 32'h7fff_ffff);
        send_cmd(CMD_MEMBER, 32'h0000_0001);
        send_cmd(CMD_REMOVE, 32'h0000_0000);
        send_cmd(CMD_MEMBER, 32'h0000_0000);
        send_cmd(CMD_REMOVE, 32'd12345);
        send_cmd(CMD_INSERT, 32'h8000_0000);
        send_cmd(CMD_DEDUPE, 32'h5a5a_5a5a);
        send_cmd(CMD_REMOVE, 32'h8000_0000);
        send_cmd(CMD_REMOVE, 32'h7fff_ffff);
        send_cmd(CMD_REMOVE, 32'hffff_ffff);
        send_cmd(CMD_REMOVE, 32'h0000_0000);
        send_cmd(CMD_MEMBER, 32'h0000_0000);

        // alternate fill and drain phases so the table swings between empty and full
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            filling = ((n / PHASE_LEN) % 2) == 0;
            quiet   = (n >= RANDOM_ITEMS - 150) || (n / PHASE_LEN == 7);
            r = $urandom_range(0, 99);
            if (filling)
                cmd = (r < 65) ? CMD_INSERT : (r < 80) ? CMD_REMOVE :
                      (r < 95) ? CMD_MEMBER : CMD_DEDUPE;
            else
                cmd = (r < 20) ? CMD_INSERT : (r < 65) ? CMD_REMOVE :
                      (r < 93) ? CMD_MEMBER : CMD_DEDUPE;
            // fresh values only on lookups so inserted values can always be drained
            if (cmd == CMD_INSERT || $urandom_range(0, 9) != 0)
                val = pool_value();
            else
                val = $urandom;
            send_cmd(cmd, val);
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("covered %0d inserts, %0d removes, %0d queries, %0d dedupes; %0d results checked",
                 cmd_counts[CMD_INSERT], cmd_counts[CMD_REMOVE], cmd_counts[CMD_MEMBER],
                 cmd_counts[CMD_DEDUPE], checked);
        $display("%0d inserts refused on a full table, %0d removes or queries of absent values",
                 full_refusals, absent_hits);
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
